FILE: hw/rtl/huffman_escape_encoder_defines.svh
// Assertion macros used by the encoder RTL (included by hfe_packer).
// Needs a signal named clock and a signal named reset in the using scope.
`ifndef HUFFMAN_ESCAPE_ENCODER_DEFINES_SVH
`define HUFFMAN_ESCAPE_ENCODER_DEFINES_SVH

// same-cycle implication
`define HFE_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("hfe assertion failed");

// next-cycle implication
`define HFE_ASSERT_NXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("hfe assertion failed");

`endif

FILE: hw/rtl/hfe_pkg.sv
// Types, constants and helpers of the Huffman escape encoder.
// No dependencies; used by all encoder modules except hfe_ram.
package hfe_pkg;

   localparam int SYMBOLS      = 256;
   localparam int SYM_W        = 8;
   localparam int MAX_CODE_LEN = 12;
   localparam int LEN_W        = 4;
   localparam int CODE_W       = 12;
   localparam int WORD_BITS    = 64;
   localparam int BITS_W       = 7;
   localparam int APP_W        = CODE_W + SYM_W;
   localparam int APP_LEN_W    = 5;
   localparam int TOTAL_W      = 32;
   localparam int COUNT_W      = 29;
   localparam int ENTRY_W      = LEN_W + CODE_W;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 8;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_ENCODE = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_SYMBOL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_LENGTH = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORDER_FLAG    = 2'd3;

   localparam logic [BITS_W-1:0] HEADER_FREE = BITS_W'(WORD_BITS - 2);
   localparam logic [BITS_W-1:0] FULL_FREE   = BITS_W'(WORD_BITS);
   localparam logic [TOTAL_W-1:0] HEADER_TOTAL = TOTAL_W'(2);

   typedef struct packed {
      logic [1:0]        command;
      logic [SYM_W-1:0]  symbol;
      logic [LEN_W-1:0]  code_length;
      logic [CODE_W-1:0] code_value;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] packed_word;
      logic [BITS_W-1:0]    word_bits;
      logic                 last_word;
      logic                 no_code_error;
      logic                 expanded;
   } rsp_payload_type;

   typedef struct packed {
      logic [LEN_W-1:0]  code_length;
      logic [CODE_W-1:0] code_value;
   } entry_type;

   typedef struct packed {
      entry_type sym_entry;
      entry_type esc_entry;
   } table_rd_type;

   typedef struct packed {
      logic             escape_enable;
      logic [SYM_W-1:0] escape_symbol;
      logic [LEN_W-1:0] escape_length;
      logic             order_flag;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic [1:0]       command;
      logic [SYM_W-1:0] symbol;
   } issue_type;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] n);
      clamp_len = (n > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : n;
   endfunction

   function automatic logic [CODE_W-1:0] keep_low(input logic [CODE_W-1:0] code,
                                                  input logic [LEN_W-1:0] n);
      keep_low = code & ~({CODE_W{1'b1}} << n);
   endfunction

endpackage

FILE: hw/rtl/huffman_escape_encoder.sv
// Huffman byte-stream encoder with a loadable 256-entry code table and an
// escape code for bytes without a code. Takes one request per cycle: a
// request is accepted when req_valid is high and req_stall low, and its table
// read issues at that edge; the packing stage then updates the 64-bit
// accumulator when not held, and a result (full word, finished partial word,
// or no-code error) goes into the result register that drives rsp_valid. The
// table read feeding the accumulator update in the packing stage sets the rate
// of one request per cycle; req_stall rises only while the packing stage holds a
// result and the result register is stalled. A load writes its entry at
// acceptance and the next request may already read it. Entries must be loaded
// before they are encoded; the table is not cleared after reset. Configuration
// writes are always taken (csr_ready is high) and belong to idle periods.
// Depends on hfe_pkg, hfe_table and hfe_packer.
module huffman_escape_encoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  hfe_pkg::req_payload_type      req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output hfe_pkg::rsp_payload_type      rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [hfe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hfe_pkg::CSR_DATA_W-1:0]  csr_data
);
   import hfe_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             accept;
   logic             hold;
   logic [SYM_W-1:0] held_symbol;
   logic [SYM_W-1:0] rd_symbol;
   issue_type        issue;
   table_rd_type     tbl_rd;
   entry_type        wr_entry;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ESCAPE_ENABLE: cfg_in.escape_enable = csr_data[0];
            CSR_ESCAPE_SYMBOL: cfg_in.escape_symbol = csr_data[SYM_W-1:0];
            CSR_ESCAPE_LENGTH: cfg_in.escape_length = csr_data[LEN_W-1:0];
            CSR_ORDER_FLAG:    cfg_in.order_flag    = csr_data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = hold;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      issue.valid   = accept && (req_payload.command inside {CMD_ENCODE, CMD_FINISH});
      issue.command = req_payload.command;
      issue.symbol  = req_payload.symbol;
      wr_entry.code_length = req_payload.code_length;
      wr_entry.code_value  = req_payload.code_value;
      rd_symbol = hold ? held_symbol : req_payload.symbol;
   end

   hfe_table u_table (
      .clock      (clock),
      .wr_en      (accept && req_payload.command == CMD_LOAD),
      .wr_symbol  (req_payload.symbol),
      .wr_entry   (wr_entry),
      .rd_symbol  (rd_symbol),
      .esc_symbol (cfg_ff.escape_symbol),
      .rd         (tbl_rd)
   );

   hfe_packer u_packer (
      .clock       (clock),
      .reset       (reset),
      .issue       (issue),
      .tbl_rd      (tbl_rd),
      .cfg         (cfg_ff),
      .hold        (hold),
      .held_symbol (held_symbol),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: hw/rtl/hfe_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module hfe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/hfe_table.sv
// Code table: two mirrored RAM copies, one read at the byte, one at the escape entry.
// Depends on hfe_pkg and hfe_ram.
module hfe_table (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [hfe_pkg::SYM_W-1:0] wr_symbol,
   input  hfe_pkg::entry_type      wr_entry,
   input  logic [hfe_pkg::SYM_W-1:0] rd_symbol,
   input  logic [hfe_pkg::SYM_W-1:0] esc_symbol,
   output hfe_pkg::table_rd_type   rd
);
   import hfe_pkg::*;

   logic [ENTRY_W-1:0] sym_data;
   logic [ENTRY_W-1:0] esc_data;

   hfe_ram #(.WIDTH(ENTRY_W), .DEPTH(SYMBOLS)) u_sym_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_symbol),
      .wr_data (wr_entry),
      .rd_addr (rd_symbol),
      .rd_data (sym_data)
   );

   hfe_ram #(.WIDTH(ENTRY_W), .DEPTH(SYMBOLS)) u_esc_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_symbol),
      .wr_data (wr_entry),
      .rd_addr (esc_symbol),
      .rd_data (esc_data)
   );

   assign rd.sym_entry = entry_type'(sym_data);
   assign rd.esc_entry = entry_type'(esc_data);

endmodule

FILE: hw/rtl/hfe_packer.sv
// Packing stage: bit accumulator, stream counters and result register.
// Depends on hfe_pkg and the assertion macro header.
`include "huffman_escape_encoder_defines.svh"
module hfe_packer (
   input  logic                    clock,
   input  logic                    reset,
   input  hfe_pkg::issue_type      issue,
   input  hfe_pkg::table_rd_type   tbl_rd,
   input  hfe_pkg::cfg_type        cfg,
   output logic                    hold,
   output logic [hfe_pkg::SYM_W-1:0] held_symbol,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output hfe_pkg::rsp_payload_type rsp_payload
);
   import hfe_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   logic [1:0]           s1_cmd_ff, s1_cmd_in;
   logic [SYM_W-1:0]     s1_sym_ff, s1_sym_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [BITS_W-1:0]    free_ff, free_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_ff, rsp_in;

   logic [LEN_W-1:0]     n_len;
   logic [LEN_W-1:0]     esc_len;
   logic                 is_esc;
   logic                 no_code;
   logic [APP_W-1:0]     app_code;
   logic [APP_LEN_W-1:0] app_len;
   logic [8:0]           rem;
   logic [8:0]           over_w;
   logic [BITS_W-1:0]    over;
   logic                 full;
   logic [WORD_BITS-1:0] ext;
   logic                 has_result;
   logic                 go;
   logic                 out_free;
   rsp_payload_type      result;

   always_comb begin
      n_len    = clamp_len(tbl_rd.sym_entry.code_length);
      esc_len  = clamp_len(cfg.escape_length);
      is_esc   = (n_len == '0);
      no_code  = is_esc && !cfg.escape_enable;
      if (is_esc) begin
         app_code = {keep_low(tbl_rd.esc_entry.code_value, esc_len), s1_sym_ff};
         app_len  = APP_LEN_W'(esc_len) + APP_LEN_W'(SYM_W);
      end else begin
         app_code = APP_W'(keep_low(tbl_rd.sym_entry.code_value, n_len));
         app_len  = APP_LEN_W'(n_len);
      end
      rem    = {2'b00, free_ff} - {4'b0000, app_len};
      over_w = {4'b0000, app_len} - {2'b00, free_ff};
      over   = over_w[BITS_W-1:0];
      full   = rem[8] || (rem == '0);
      ext    = WORD_BITS'(app_code);
   end

   always_comb begin
      acc_in   = acc_ff;
      free_in  = free_ff;
      total_in = total_ff;
      count_in = count_ff;
      result   = '0;
      has_result = 1'b0;
      case (s1_cmd_ff)
         CMD_ENCODE: begin
            if (no_code) begin
               has_result           = 1'b1;
               result.no_code_error = 1'b1;
            end else begin
               total_in = total_ff + TOTAL_W'(app_len);
               count_in = count_ff + COUNT_W'(1);
               if (full) begin
                  has_result         = 1'b1;
                  result.packed_word = acc_ff | (ext >> over);
                  result.word_bits   = FULL_FREE;
                  acc_in             = ext << (FULL_FREE - over);
                  free_in            = FULL_FREE - over;
               end else begin
                  acc_in  = acc_ff | (ext << rem[BITS_W-1:0]);
                  free_in = rem[BITS_W-1:0];
               end
            end
         end
         CMD_FINISH: begin
            has_result         = 1'b1;
            result.packed_word = acc_ff;
            result.word_bits   = FULL_FREE - free_ff;
            result.last_word   = 1'b1;
            result.expanded    = total_ff > {count_ff, 3'b000};
            acc_in   = {1'b0, cfg.order_flag, {(WORD_BITS-2){1'b0}}};
            free_in  = HEADER_FREE;
            total_in = HEADER_TOTAL;
            count_in = '0;
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign hold        = s1_valid_ff && has_result && !out_free;
   assign go          = s1_valid_ff && !hold;
   assign held_symbol = s1_sym_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_cmd_in   = s1_cmd_ff;
      s1_sym_in   = s1_sym_ff;
      if (!hold) begin
         s1_valid_in = issue.valid;
         s1_cmd_in   = issue.command;
         s1_sym_in   = issue.symbol;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (go && has_result) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         free_ff      <= HEADER_FREE;
         total_ff     <= HEADER_TOTAL;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (go) begin
            acc_ff   <= acc_in;
            free_ff  <= free_in;
            total_ff <= total_in;
            count_ff <= count_in;
         end
      end
      s1_cmd_ff <= s1_cmd_in;
      s1_sym_ff <= s1_sym_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `HFE_ASSERT_IMP(a_free_range, 1'b1, free_ff != '0 && free_ff <= FULL_FREE)
   `HFE_ASSERT_IMP(a_hold_cause, hold, s1_valid_ff && rsp_valid_ff && rsp_stall)
   `HFE_ASSERT_IMP(a_err_empty, rsp_valid_ff && rsp_ff.no_code_error,
                   rsp_ff.word_bits == '0 && !rsp_ff.last_word)
   `HFE_ASSERT_NXT(a_finish_restart, go && s1_cmd_ff == CMD_FINISH,
                   free_ff == HEADER_FREE && count_ff == '0)

endmodule
